>>> sv/mtt_pkg.sv
// Shared codes, field widths and the result record of the timer table.
// No dependencies; the top and the checker refer to it by scoped names.
`default_nettype none

package mtt_pkg;

	localparam int KIND_W  = 2;
	localparam int DELTA_W = 16;
	localparam int WAIT_W  = 32;
	localparam int CNT_W   = 16;
	localparam int OWNER_W = 8;
	localparam int SLOT_W  = 4;
	localparam int EV_W    = 3;

	// at most this many fire events are reported for one tick
	localparam int MAX_RES = 16;
	localparam int NRES_W  = 5;

	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

	localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
	localparam logic [EV_W-1:0] EV_REPEAT = 3'd1;
	localparam logic [EV_W-1:0] EV_FINAL  = 3'd2;
	localparam logic [EV_W-1:0] EV_SET_OK = 3'd3;
	localparam logic [EV_W-1:0] EV_FULL   = 3'd4;
	localparam logic [EV_W-1:0] EV_CANCEL = 3'd5;

	typedef struct packed {
		logic [EV_W-1:0]    ev;
		logic [SLOT_W-1:0]  slot;
		logic [OWNER_W-1:0] owner;
	} res_t;

endpackage

`default_nettype wire

>>> sv/mtt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module mtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                    clk,
	input  wire                    we,
	input  wire [AW-1:0]           waddr,
	input  wire [WIDTH-1:0]        wdata,
	input  wire                    re,
	input  wire [AW-1:0]           raddr,
	output logic [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/multi_timer_table_top.sv
// Timer table: a tick walks all slots, reading each entry from the registered-read RAM
// ahead of its update and writing back fired entries. Cancel also walks all slots;
// set scans the valid bits for a free slot.
// A new request is taken once the previous one has handed its final result to the
// output register; output stalls extend the walk. Reset clears the clock and the
// valid bits at once; entry RAM contents need no clearing pass.
`default_nettype none

module multi_timer_table_top #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [mtt_pkg::KIND_W-1:0]    kind,
	input  wire [mtt_pkg::DELTA_W-1:0]   delta_time,
	input  wire [mtt_pkg::WAIT_W-1:0]    period,
	input  wire [mtt_pkg::WAIT_W-1:0]    first_wait,
	input  wire                          use_first_wait,
	input  wire [mtt_pkg::CNT_W-1:0]     repeat_count,
	input  wire [mtt_pkg::OWNER_W-1:0]   owner_id,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [mtt_pkg::EV_W-1:0]     event_res,
	output logic [mtt_pkg::SLOT_W-1:0]   slot,
	output logic [mtt_pkg::OWNER_W-1:0]  owner,
	output logic                         last
);

	localparam int IW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW   = $clog2(NUM_TIMERS + 1) > IW ? $clog2(NUM_TIMERS + 1) : IW;
	localparam int CMPW = (TIME_WIDTH > mtt_pkg::WAIT_W) ? TIME_WIDTH : mtt_pkg::WAIT_W;

	typedef struct packed {
		logic [TIME_WIDTH-1:0]       start;
		logic [mtt_pkg::WAIT_W-1:0]  period;
		logic [mtt_pkg::WAIT_W-1:0]  first_wait;
		logic                        first_pending;
		logic [mtt_pkg::CNT_W-1:0]   remaining;
		logic [mtt_pkg::OWNER_W-1:0] owner;
	} entry_t;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_SCAN, S_FIN} state_t;

	state_t                      state_q;
	logic [TIME_WIDTH-1:0]       clock_q;
	logic [NUM_TIMERS-1:0]       valid_q;
	logic [CW-1:0]               addr_q;
	logic                        vld_s1;
	logic [IW-1:0]               idx_s1;
	logic [mtt_pkg::NRES_W-1:0]  n_q;
	logic                        hold_vld_q;
	mtt_pkg::res_t               hold_q;
	mtt_pkg::res_t               res_q;
	mtt_pkg::res_t               out_q;
	logic                        out_last_q;
	logic                        out_valid_q;

	// captured request
	logic [mtt_pkg::KIND_W-1:0]  kind_q;
	logic [mtt_pkg::WAIT_W-1:0]  period_q;
	logic [mtt_pkg::WAIT_W-1:0]  first_wait_q;
	logic                        use_first_q;
	logic [mtt_pkg::CNT_W-1:0]   repeat_q;
	logic [mtt_pkg::OWNER_W-1:0] owner_q;

	entry_t                      rd_entry;
	entry_t                      upd_entry;
	entry_t                      set_entry;
	entry_t                      wr_entry;
	logic                        ram_we;
	logic [IW-1:0]               ram_waddr;
	logic                        ram_re;

	logic                        accept;
	logic                        is_tick;
	logic                        cur_valid;
	logic [TIME_WIDTH-1:0]       elapsed;
	logic [mtt_pkg::WAIT_W-1:0]  wait_v;
	logic                        fire;
	logic                        is_final;
	logic                        cancel_hit;
	logic                        report;
	logic                        need_push;
	logic                        out_free;
	logic                        load_out;
	logic                        adv;
	logic                        issue;
	logic                        walk_done;
	logic                        scan_end;
	logic                        scan_hit;
	logic [IW-1:0]               scan_idx;
	logic [mtt_pkg::EV_W-1:0]    fire_ev;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign is_tick  = (kind_q == mtt_pkg::KIND_TICK);
	assign out_free = !out_valid_q || !out_stall;
	assign issue    = (addr_q < CW'(NUM_TIMERS));
	assign scan_idx = addr_q[IW-1:0];
	assign scan_end = !issue;
	assign scan_hit = (state_q == S_SCAN) && !scan_end && !valid_q[scan_idx];

	always_comb begin
		cur_valid  = valid_q[idx_s1];
		elapsed    = clock_q - rd_entry.start;
		wait_v     = rd_entry.first_pending ? rd_entry.first_wait : rd_entry.period;
		fire       = (state_q == S_WALK) && is_tick && vld_s1 && cur_valid &&
		             (CMPW'(elapsed) >= CMPW'(wait_v));
		cancel_hit = (state_q == S_WALK) && !is_tick && vld_s1 && cur_valid &&
		             (rd_entry.owner == owner_q);
		report     = fire && (n_q < mtt_pkg::NRES_W'(mtt_pkg::MAX_RES));
		need_push  = report && hold_vld_q;
		adv        = !(need_push && !out_free);
		walk_done  = (state_q == S_WALK) && !vld_s1 && !issue;
		// output register loads a mid-walk fire or the final result
		load_out   = out_free && (need_push || (state_q == S_FIN));

		// a counted timer at its last repeat is freed and keeps its start stamp
		is_final   = (rd_entry.remaining == mtt_pkg::CNT_W'(1));
		upd_entry  = rd_entry;
		upd_entry.first_pending = 1'b0;
		if (rd_entry.remaining != '0) begin
			upd_entry.remaining = rd_entry.remaining - mtt_pkg::CNT_W'(1);
		end
		if (!is_final) begin
			upd_entry.start = clock_q;
		end
		fire_ev = is_final ? mtt_pkg::EV_FINAL : mtt_pkg::EV_REPEAT;

		set_entry.start         = clock_q;
		set_entry.period        = period_q;
		set_entry.first_wait    = use_first_q ? first_wait_q : period_q;
		set_entry.first_pending = 1'b1;
		set_entry.remaining     = repeat_q;
		set_entry.owner         = owner_q;

		ram_we    = (fire && adv) || scan_hit;
		ram_waddr = scan_hit ? scan_idx : idx_s1;
		wr_entry  = scan_hit ? set_entry : upd_entry;
		ram_re    = (state_q == S_WALK) && issue && adv;
	end

	mtt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NUM_TIMERS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(addr_q[IW-1:0]),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clock_q     <= '0;
			valid_q     <= '0;
			addr_q      <= '0;
			vld_s1      <= 1'b0;
			n_q         <= '0;
			hold_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			out_last_q  <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					addr_q     <= '0;
					vld_s1     <= 1'b0;
					n_q        <= '0;
					hold_vld_q <= 1'b0;
					if (accept) begin
						priority if (kind == mtt_pkg::KIND_TICK) begin
							clock_q <= clock_q + TIME_WIDTH'(delta_time);
							state_q <= S_WALK;
						end else if (kind == mtt_pkg::KIND_CANCEL) begin
							state_q <= S_WALK;
						end else if (kind == mtt_pkg::KIND_SET) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_WALK: begin
					if (walk_done) begin
						state_q <= S_FIN;
					end else if (adv) begin
						vld_s1 <= issue;
						addr_q <= addr_q + CW'(issue);
						if (fire && is_final) begin
							valid_q[idx_s1] <= 1'b0;
						end
						if (cancel_hit) begin
							valid_q[idx_s1] <= 1'b0;
						end
						if (report) begin
							n_q        <= n_q + mtt_pkg::NRES_W'(1);
							hold_vld_q <= 1'b1;
						end
						// previous fire is not the last one: send it on
						if (need_push) begin
							out_q      <= hold_q;
							out_last_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (scan_end || scan_hit) begin
						state_q <= S_FIN;
					end else begin
						addr_q <= addr_q + CW'(1);
					end
					if (scan_hit) begin
						valid_q[scan_idx] <= 1'b1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_q      <= res_q;
						out_last_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= kind;
			period_q     <= period;
			first_wait_q <= first_wait;
			use_first_q  <= use_first_wait;
			repeat_q     <= repeat_count;
			owner_q      <= owner_id;
		end
		if (state_q == S_WALK && !walk_done && adv) begin
			idx_s1 <= addr_q[IW-1:0];
			if (report) begin
				hold_q.ev    <= fire_ev;
				hold_q.slot  <= mtt_pkg::SLOT_W'(idx_s1);
				hold_q.owner <= rd_entry.owner;
			end
		end
		if (walk_done) begin
			if (!is_tick) begin
				res_q <= '{ev: mtt_pkg::EV_CANCEL, slot: '0, owner: owner_q};
			end else if (hold_vld_q) begin
				res_q <= hold_q;
			end else begin
				res_q <= '{ev: mtt_pkg::EV_NONE, slot: '0, owner: '0};
			end
		end
		if (state_q == S_SCAN) begin
			if (scan_hit) begin
				res_q <= '{ev: mtt_pkg::EV_SET_OK, slot: mtt_pkg::SLOT_W'(scan_idx),
				           owner: owner_q};
			end else if (scan_end) begin
				res_q <= '{ev: mtt_pkg::EV_FULL, slot: '0, owner: owner_q};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = out_q.ev;
	assign slot      = out_q.slot;
	assign owner     = out_q.owner;
	assign last      = out_last_q;

endmodule

`default_nettype wire

>>> sv/mtt_checker.sv
// Port-level checks for the timer table, bound to multi_timer_table_top.
// Depends on mtt_pkg for kind codes.
`default_nettype none

module mtt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire [1:0]  kind,
	input wire        out_valid,
	input wire        out_stall,
	input wire [2:0]  event_res,
	input wire [3:0]  slot,
	input wire [7:0]  owner,
	input wire        last
);

	// a result waiting on a stall stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(slot) &&
		$stable(owner) && $stable(last))
		else $error("stalled result changed or dropped");

	// a real request makes the block busy in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == mtt_pkg::KIND_TICK ||
		kind == mtt_pkg::KIND_SET || kind == mtt_pkg::KIND_CANCEL) |=> in_stall)
		else $error("request accepted without going busy");

	// the unused kind is dropped without any work
	a_unused_kind: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !(kind == mtt_pkg::KIND_TICK ||
		kind == mtt_pkg::KIND_SET || kind == mtt_pkg::KIND_CANCEL) |=> !in_stall)
		else $error("unused kind made the block busy");

	// the block takes no new request until the previous one has sent its last result
	a_last_before_next: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid && last)
		else $error("went idle without a final result");

endmodule

bind multi_timer_table_top mtt_checker u_mtt_checker (.*);

`default_nettype wire
